[hdl/bmrf_pkg.sv]
// Shared types and constants for the bus message receiver filter.
// No dependencies; the top level, bmrf_front and bmrf_back import this package.
package bmrf_pkg;

  // Field widths fixed by the item formats
  localparam int BYTE_W    = 8;
  localparam int MSG_LEN_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;
  localparam int NUM_IDS   = 256;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERIFY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE3 = 3'd4;

  // Input op codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_IDLE = 1'b1;

  // Result kind codes
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic                 kind;
    logic [BYTE_W-1:0]    msg_byte;
    logic [MSG_LEN_W-1:0] msg_length;
    logic                 last;
  } out_item_t;

  // Live configuration seen by the front end
  typedef struct packed {
    logic               verify_checksum;
    logic [NUM_IDS-1:0] ignore_ids;
  } cfg_t;

  // Back end hands a buffer bank back to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

endpackage

[hdl/bus_message_receiver_filter.sv]
// Bus message receiver with ID filter and trailing-sum check. The front end
// takes a byte beat whenever input is ready; an idle beat closes the message
// and queues a delivery or error report unless its ID is ignored. The back
// end reads each byte from the buffer RAM (read issue, then result register)
// and issues no new read until that byte is in and the slot is free. The
// buffer has two banks: while the back end drains one, the front end fills
// the other, and input stalls only when the next bank is still draining or
// the two-entry command queue is full. No clearing pass after reset.
// Uses bmrf_pkg, bmrf_ram, bmrf_cmd_queue, bmrf_front and bmrf_back.
module bus_message_receiver_filter #(
  parameter int MAX_BYTES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bmrf_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bmrf_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [bmrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmrf_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import bmrf_pkg::*;

  localparam int ADDR_W = $clog2(MAX_BYTES) + 1;
  localparam int CNT_W  = $clog2(MAX_BYTES + 1);
  localparam int CMD_W  = CNT_W + 2;

  logic                 verify_r;
  logic [CFG_DAT_W-1:0] ignore0_r, ignore1_r, ignore2_r, ignore3_r;
  cfg_t                 cfg;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              cmd_push, cmd_full, cmd_pop, cmd_valid;
  logic [CMD_W-1:0]  cmd_in, cmd_out;
  bank_rel_t         bank_rel;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      verify_r  <= 1'b1;
      ignore0_r <= '0;
      ignore1_r <= '0;
      ignore2_r <= '0;
      ignore3_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERIFY:  verify_r  <= cfg_wdata[0];
        CFG_IGNORE0: ignore0_r <= cfg_wdata;
        CFG_IGNORE1: ignore1_r <= cfg_wdata;
        CFG_IGNORE2: ignore2_r <= cfg_wdata;
        CFG_IGNORE3: ignore3_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Pack live settings: verify flag above the 256-bit ID map
  assign cfg = {verify_r, ignore3_r, ignore2_r, ignore1_r, ignore0_r};

  bmrf_front #(
    .MAX_BYTES(MAX_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in),
    .cmd_full (cmd_full),
    .bank_rel (bank_rel)
  );

  bmrf_cmd_queue #(
    .WIDTH(CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .not_empty (cmd_valid),
    .pop_data  (cmd_out)
  );

  bmrf_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(2 << $clog2(MAX_BYTES))
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bmrf_back #(
    .MAX_BYTES(MAX_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .bank_rel  (bank_rel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[hdl/bmrf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/bmrf_cmd_queue.sv]
// Two-entry command queue between the front end and the back end.
// No dependencies.
module bmrf_cmd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hdl/bmrf_front.sv]
// Front end: takes input beats, fills the current buffer bank, tracks the
// running sums and classifies each closed message. Uses bmrf_pkg.
module bmrf_front #(
  parameter int MAX_BYTES = 16
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  bmrf_pkg::in_item_t                              in_data,
  input  bmrf_pkg::cfg_t                                  cfg,
  output logic                                            wr_en,
  output logic [$clog2(MAX_BYTES):0]                      wr_addr,
  output logic [bmrf_pkg::BYTE_W-1:0]                     wr_data,
  output logic                                            cmd_push,
  output logic [$clog2(MAX_BYTES+1)+1:0]                  cmd_data,
  input  logic                                            cmd_full,
  input  bmrf_pkg::bank_rel_t                             bank_rel
);
  import bmrf_pkg::*;

  localparam int IDX_W = $clog2(MAX_BYTES);
  localparam int CNT_W = $clog2(MAX_BYTES + 1);

  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [BYTE_W-1:0] sum_all_r, sum_all_nxt;
  logic [BYTE_W-1:0] sum_prev_r, sum_prev_nxt;
  logic [BYTE_W-1:0] id_r, id_nxt;
  logic [BYTE_W-1:0] last_byte_r, last_byte_nxt;
  logic              cur_bank_r, cur_bank_nxt;
  logic [1:0]        busy_r, busy_nxt;

  logic accept;
  logic take_byte;
  logic close_msg;
  logic ignored;
  logic sum_bad;

  // Stall while the current bank is still being drained or the queue is full
  assign in_ready  = !busy_r[cur_bank_r] && !cmd_full;
  assign accept    = in_valid && in_ready;
  assign take_byte = accept && (in_data.op == OP_BYTE) && (fill_r < CNT_W'(MAX_BYTES));
  assign close_msg = accept && (in_data.op == OP_IDLE) && (fill_r != '0);

  // Classify the closed message
  assign ignored = cfg.ignore_ids[id_r];
  assign sum_bad = cfg.verify_checksum && (fill_r > CNT_W'(1)) && (sum_prev_r != last_byte_r);

  // Write the byte into the current bank
  assign wr_en   = take_byte;
  assign wr_addr = {cur_bank_r, fill_r[IDX_W-1:0]};
  assign wr_data = in_data.rx_byte;

  // Queue a delivery or an error report; ignored messages vanish here
  assign cmd_push = close_msg && !ignored;
  assign cmd_data = {sum_bad, cur_bank_r, fill_r};

  always_comb begin
    fill_nxt      = fill_r;
    sum_all_nxt   = sum_all_r;
    sum_prev_nxt  = sum_prev_r;
    id_nxt        = id_r;
    last_byte_nxt = last_byte_r;
    cur_bank_nxt  = cur_bank_r;
    busy_nxt      = busy_r;
    if (bank_rel.valid) begin
      busy_nxt[bank_rel.bank] = 1'b0;
    end
    if (take_byte) begin
      fill_nxt      = fill_r + CNT_W'(1);
      sum_prev_nxt  = sum_all_r;
      sum_all_nxt   = sum_all_r + in_data.rx_byte;
      last_byte_nxt = in_data.rx_byte;
      if (fill_r == '0) begin
        id_nxt = in_data.rx_byte;
      end
    end
    if (close_msg) begin
      fill_nxt     = '0;
      sum_all_nxt  = '0;
      sum_prev_nxt = '0;
      // Hand the bank over and switch to the other one
      if (!ignored && !sum_bad) begin
        busy_nxt[cur_bank_r] = 1'b1;
        cur_bank_nxt         = ~cur_bank_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      sum_all_r  <= '0;
      sum_prev_r <= '0;
      cur_bank_r <= 1'b0;
      busy_r     <= 2'b00;
    end else begin
      fill_r     <= fill_nxt;
      sum_all_r  <= sum_all_nxt;
      sum_prev_r <= sum_prev_nxt;
      cur_bank_r <= cur_bank_nxt;
      busy_r     <= busy_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    last_byte_r <= last_byte_nxt;
  end

endmodule

[hdl/bmrf_back.sv]
// Back end: pops commands, reads message bytes from the buffer bank and
// drives the result register. Uses bmrf_pkg.
module bmrf_back #(
  parameter int MAX_BYTES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cmd_valid,
  input  logic [$clog2(MAX_BYTES+1)+1:0]      cmd_data,
  output logic                                cmd_pop,
  output logic                                rd_en,
  output logic [$clog2(MAX_BYTES):0]          rd_addr,
  input  logic [bmrf_pkg::BYTE_W-1:0]         rd_data,
  output bmrf_pkg::bank_rel_t                 bank_rel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bmrf_pkg::out_item_t                 out_data
);
  import bmrf_pkg::*;

  localparam int IDX_W = $clog2(MAX_BYTES);
  localparam int CNT_W = $clog2(MAX_BYTES + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ERR  = 3'b010,
    ST_READ = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             bank_r, bank_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             rd_last_r, rd_last_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic slot_free;
  logic at_last;

  // Output slot can take new data once no read is pending and current beat leaves
  assign slot_free = !rd_pend_r && (!out_valid_r || out_ready);
  assign at_last   = (idx_r == len_r - CNT_W'(1));

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign rd_addr   = {bank_r, idx_r[IDX_W-1:0]};

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    bank_nxt      = bank_r;
    rd_pend_nxt   = 1'b0;
    rd_last_nxt   = rd_last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cmd_pop       = 1'b0;
    rd_en         = 1'b0;
    bank_rel      = '0;

    // Drop the result beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Load byte read in previous cycle
    if (rd_pend_r) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.kind       = KIND_BYTE;
      out_data_nxt.msg_byte   = rd_data;
      out_data_nxt.msg_length = MSG_LEN_W'(len_r);
      out_data_nxt.last       = rd_last_r;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          len_nxt  = cmd_data[CNT_W-1:0];
          bank_nxt = cmd_data[CNT_W];
          idx_nxt  = '0;
          state_nxt = cmd_data[CNT_W+1] ? ST_ERR : ST_READ;
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.kind       = KIND_ERROR;
          out_data_nxt.msg_byte   = '0;
          out_data_nxt.msg_length = MSG_LEN_W'(len_r);
          out_data_nxt.last       = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end
      ST_READ: begin
        // Issue one read; data lands next cycle
        if (slot_free) begin
          rd_en       = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_last_nxt = at_last;
          idx_nxt     = idx_r + CNT_W'(1);
          if (at_last) begin
            bank_rel.valid = 1'b1;
            bank_rel.bank  = bank_r;
            state_nxt      = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    bank_r     <= bank_nxt;
    rd_last_r  <= rd_last_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
